// ----- src/pbd_pkg.sv -----
// Package: shared types and codes of the push-button dimmer controller.
`timescale 1ns / 1ps
`default_nettype none

package pbd_pkg;

    // Event codes of the request func field
    localparam logic [1:0] FUNC_LEVEL = 2'd0;
    localparam logic [1:0] FUNC_TICK  = 2'd1;
    localparam logic [1:0] FUNC_BUS   = 2'd2;

    // Result target codes
    localparam logic TARGET_SWITCH = 1'b0;
    localparam logic TARGET_DIM    = 1'b1;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_ONE_BUTTON_MODE   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIRECTION_INVERSE = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_ODD       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_DOWN_CODE    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_UP_CODE      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_LONG_PRESS_TICKS  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPEAT_TICKS      = 3'd6;

    // Reset values of the configuration registers
    localparam logic        RST_ONE_BUTTON_MODE  = 1'b1;
    localparam logic [15:0] RST_LONG_PRESS_TICKS = 16'd500;

    localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

    typedef struct packed {
        logic [1:0] func;
        logic       level;
        logic       bus_state;
    } in_t;

    typedef struct packed {
        logic       target;
        logic [7:0] value;
    } out_t;

endpackage : pbd_pkg

`default_nettype wire

// ----- src/push_button_dimmer_control.sv -----
// Top level of the push-button dimmer controller.
`timescale 1ns / 1ps
`default_nettype none

// Push-button dimmer controller for relative dimming with one or two buttons.
// Each input request is one event: a button level change (func 0), a time tick
// (func 1) or a bus update of the switch-state object (func 2); func 3 is
// ignored. A press starts the long-press timer. A release before expiry sends
// a switch value (target 0); expiry sends a dim step (target 1) and arms a
// pending stop, and the following release sends dim value 0. In one-button
// mode the switch value toggles and each stop reverses the dim direction;
// with a nonzero repeat_ticks the dim step repeats at that interval while the
// button is held. Timing: a request is captured in an input register, its
// event is evaluated combinationally against the controller state and any
// result lands in the output register, so one request is taken per clock
// cycle unless a held result stalls the input, which only happens once both
// the input and output registers are full. Events that produce no result
// still pass through the output stage slot but never show out_valid.
// Configuration is a plain write port (cfg_write, cfg_index, cfg_data) and
// must only be used while the block is idle; unknown indexes are ignored.
module push_button_dimmer_control
    import pbd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,

    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire in_t                    in_data,

    output logic                        out_valid,
    input  wire logic                   out_ready,
    output out_t                        out_data
);

    // Configuration registers
    logic        one_button_mode_reg;
    logic        direction_inverse_reg;
    logic        channel_odd_reg;
    logic [7:0]  step_down_code_reg;
    logic [7:0]  step_up_code_reg;
    logic [15:0] long_press_ticks_reg;
    logic [15:0] repeat_ticks_reg;

    // Controller state
    logic        timer_running_reg, timer_running_next;
    logic [15:0] timer_elapsed_reg, timer_elapsed_next;
    logic        stop_pending_reg, stop_pending_next;
    logic        direction_flip_reg, direction_flip_next;
    logic        switch_state_reg, switch_state_next;
    logic        in_repeat_reg, in_repeat_next;

    // Pipeline registers
    logic        req_valid_reg;
    in_t         req_reg;
    logic        out_valid_reg, out_valid_next;
    out_t        out_data_reg, out_data_next;

    logic        process;
    logic        cur_dir;
    logic [15:0] elapsed_inc;
    logic [15:0] timer_len;
    logic        emit;
    out_t        result;

    // The request in the input register is evaluated when the output slot
    // is free or being emptied this cycle.
    assign process  = req_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !req_valid_reg || process;

    assign cur_dir     = direction_inverse_reg ^ direction_flip_reg;
    assign elapsed_inc = (timer_elapsed_reg == ELAPSED_MAX) ? timer_elapsed_reg
                                                            : timer_elapsed_reg + 16'd1;
    assign timer_len   = in_repeat_reg ? repeat_ticks_reg : long_press_ticks_reg;

    // Event evaluation
    always_comb
    begin
        timer_running_next  = timer_running_reg;
        timer_elapsed_next  = timer_elapsed_reg;
        stop_pending_next   = stop_pending_reg;
        direction_flip_next = direction_flip_reg;
        switch_state_next   = switch_state_reg;
        in_repeat_next      = in_repeat_reg;
        emit                = 1'b0;
        result.target       = TARGET_SWITCH;
        result.value        = 8'd0;

        unique case (req_reg.func)
            FUNC_LEVEL:
            begin
                if (req_reg.level)
                begin
                    // press (or re-press): restart the long-press timer
                    timer_running_next = 1'b1;
                    timer_elapsed_next = 16'd0;
                    in_repeat_next     = 1'b0;
                end
                else if (stop_pending_reg)
                begin
                    // release after dimming: send stop
                    stop_pending_next  = 1'b0;
                    timer_running_next = 1'b0;
                    if (one_button_mode_reg)
                        direction_flip_next = ~direction_flip_reg;
                    emit          = 1'b1;
                    result.target = TARGET_DIM;
                    result.value  = 8'd0;
                end
                else if (timer_running_reg)
                begin
                    // short press: send a switch value
                    timer_running_next = 1'b0;
                    emit               = 1'b1;
                    result.target      = TARGET_SWITCH;
                    if (one_button_mode_reg)
                    begin
                        switch_state_next = ~switch_state_reg;
                        result.value      = {7'd0, ~switch_state_reg};
                    end
                    else
                    begin
                        result.value = {7'd0, cur_dir ? channel_odd_reg : ~channel_odd_reg};
                    end
                end
                else
                begin
                    timer_running_next = 1'b0;
                end
            end
            FUNC_TICK:
            begin
                if (timer_running_reg)
                begin
                    timer_elapsed_next = elapsed_inc;
                    if (elapsed_inc >= timer_len)
                    begin
                        // expiry: send a dim step, arm the stop
                        if (one_button_mode_reg && (repeat_ticks_reg != 16'd0))
                        begin
                            timer_elapsed_next = 16'd0;
                            in_repeat_next     = 1'b1;
                        end
                        else
                        begin
                            timer_running_next = 1'b0;
                        end
                        stop_pending_next = 1'b1;
                        emit              = 1'b1;
                        result.target     = TARGET_DIM;
                        result.value      = cur_dir ? step_down_code_reg : step_up_code_reg;
                    end
                end
            end
            FUNC_BUS:
            begin
                switch_state_next = req_reg.bus_state;
            end
            default:
            begin
                // unused code: no effect
            end
        endcase
    end

    // Output stage next values
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (process)
        begin
            out_valid_next = emit;
            out_data_next  = result;
        end
    end

    // Control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            one_button_mode_reg   <= RST_ONE_BUTTON_MODE;
            direction_inverse_reg <= 1'b0;
            channel_odd_reg       <= 1'b0;
            step_down_code_reg    <= 8'd0;
            step_up_code_reg      <= 8'd0;
            long_press_ticks_reg  <= RST_LONG_PRESS_TICKS;
            repeat_ticks_reg      <= 16'd0;
            timer_running_reg     <= 1'b0;
            timer_elapsed_reg     <= 16'd0;
            stop_pending_reg      <= 1'b0;
            direction_flip_reg    <= 1'b0;
            switch_state_reg      <= 1'b0;
            in_repeat_reg         <= 1'b0;
            req_valid_reg         <= 1'b0;
            out_valid_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_ONE_BUTTON_MODE:   one_button_mode_reg   <= cfg_data[0];
                    CFG_DIRECTION_INVERSE: direction_inverse_reg <= cfg_data[0];
                    CFG_CHANNEL_ODD:       channel_odd_reg       <= cfg_data[0];
                    CFG_STEP_DOWN_CODE:    step_down_code_reg    <= cfg_data[7:0];
                    CFG_STEP_UP_CODE:      step_up_code_reg      <= cfg_data[7:0];
                    CFG_LONG_PRESS_TICKS:  long_press_ticks_reg  <= cfg_data;
                    CFG_REPEAT_TICKS:      repeat_ticks_reg      <= cfg_data;
                    default:
                    begin
                        // unknown index: ignored
                    end
                endcase
            end

            if (process)
            begin
                timer_running_reg  <= timer_running_next;
                timer_elapsed_reg  <= timer_elapsed_next;
                stop_pending_reg   <= stop_pending_next;
                direction_flip_reg <= direction_flip_next;
                switch_state_reg   <= switch_state_next;
                in_repeat_reg      <= in_repeat_next;
            end

            if (in_ready)
                req_valid_reg <= in_valid;

            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            req_reg <= in_data;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule : push_button_dimmer_control

`default_nettype wire
